@@ hdl/tccs_pkg.sv @@
// shared types and constants for the text console engine
// no dependencies; used by every module of the block except tccs_fifo
package tccs_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // command queue and result queue depth
    localparam int QUEUE_DEPTH = 2;

    // field widths
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int TAB_W   = 4;

    // cell values
    localparam logic [CHAR_W-1:0]  BLANK_CHAR  = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
    localparam logic [COLOR_W-1:0] RESET_FILL  = 8'h07;
    localparam logic [TAB_W-1:0]   RESET_TAB   = 4'd4;

    // control characters
    localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;

    // configuration register indexes
    localparam logic CFG_FILL_COLOR = 1'b0;
    localparam logic CFG_TAB_WIDTH  = 1'b1;

    // operation codes of an input item
    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // classified command handed from front to back
    typedef enum logic [2:0] {
        CMD_GLYPH   = 3'd0,
        CMD_NEWLINE = 3'd1,
        CMD_RETURN  = 3'd2,
        CMD_TAB     = 3'd3,
        CMD_CLEAR   = 3'd4,
        CMD_READ    = 3'd5,
        CMD_NOP     = 3'd6
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [CHAR_W-1:0] ch;
        logic [6:0]        rd_col;
        logic [4:0]        rd_row;
    } t_cmd_item;

    typedef struct packed {
        logic [6:0]         cursor_col;
        logic [4:0]         cursor_row;
        logic [10:0]        cursor_position;
        logic [CHAR_W-1:0]  cell_char;
        logic [COLOR_W-1:0] cell_color;
    } t_result;

    // engine sequencer states
    typedef enum logic [2:0] {
        ST_INIT  = 3'd0,
        ST_IDLE  = 3'd1,
        ST_TAB   = 3'd2,
        ST_MOVE  = 3'd3,
        ST_FILL  = 3'd4,
        ST_CLEAR = 3'd5,
        ST_READ  = 3'd6
    } t_state;

endpackage

@@ hdl/tccs_fifo.sv @@
// small synchronous queue with registered storage
// generic payload width; depth from the instantiating module
module tccs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

@@ hdl/tccs_front.sv @@
// front end: classifies an incoming item into an engine command
// depends on tccs_pkg
module tccs_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 i_push,
    input  logic [1:0]           i_operation,
    input  logic [7:0]           i_char_code,
    input  logic [6:0]           i_read_col,
    input  logic [4:0]           i_read_row,
    output logic                 o_cmd_push,
    output tccs_pkg::t_cmd_item  o_cmd
);

    import tccs_pkg::*;

    localparam logic [7:0] COL_LIM = 8'(COLUMNS);
    localparam logic [6:0] ROW_LIM = 7'(ROWS);

    logic in_screen;

    // reads outside the screen become no-ops
    assign in_screen = (8'(i_read_col) < COL_LIM) && (7'(i_read_row) < ROW_LIM);
    assign o_cmd_push = i_push;

    always_comb begin
        o_cmd.ch     = i_char_code;
        o_cmd.rd_col = i_read_col;
        o_cmd.rd_row = i_read_row;
        o_cmd.kind   = CMD_NOP;
        unique case (i_operation)
            OP_PUT: begin
                unique case (i_char_code)
                    CHAR_TAB: o_cmd.kind = CMD_TAB;
                    CHAR_LF:  o_cmd.kind = CMD_NEWLINE;
                    CHAR_CR:  o_cmd.kind = CMD_RETURN;
                    default:  o_cmd.kind = CMD_GLYPH;
                endcase
            end
            OP_CLEAR: o_cmd.kind = CMD_CLEAR;
            OP_READ:  o_cmd.kind = in_screen ? CMD_READ : CMD_NOP;
            default:  o_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

@@ hdl/tccs_back.sv @@
// back end: cursor, character and color stores, scroll and clear sequencer
// depends on tccs_pkg
module tccs_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tccs_pkg::t_cmd_item i_cmd,
    input  logic                i_cmd_empty,
    output logic                o_cmd_pop,
    output tccs_pkg::t_result   o_res,
    output logic                o_res_push,
    input  logic                i_res_full,
    input  logic [7:0]          i_fill_color,
    input  logic [3:0]          i_tab_width,
    output logic                o_init_busy
);

    import tccs_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int X_W   = $clog2(COLUMNS);
    localparam int Y_W   = $clog2(ROWS);
    localparam int A_W   = $clog2(CELLS);

    localparam logic [X_W-1:0] X_LAST     = X_W'(COLUMNS - 1);
    localparam logic [Y_W-1:0] Y_LAST     = Y_W'(ROWS - 1);
    localparam logic [A_W-1:0] COL_A      = A_W'(COLUMNS);
    localparam logic [A_W-1:0] CELL_LAST  = A_W'(CELLS - 1);
    localparam logic [A_W-1:0] BOTTOM_ROW = A_W'(CELLS - COLUMNS);

    // stores
    logic [CHAR_W-1:0]  r_char_mem  [CELLS];
    logic [COLOR_W-1:0] r_color_mem [CELLS];
    logic [CHAR_W-1:0]  r_rd_char;
    logic [COLOR_W-1:0] r_rd_color;

    t_state         r_state, n_state;
    logic [X_W-1:0] r_x, n_x;
    logic [Y_W-1:0] r_y, n_y;
    logic [A_W-1:0] r_base, n_base;
    logic [A_W-1:0] r_addr, n_addr;
    logic [TAB_W-1:0] r_tab_left, n_tab_left;
    logic           r_resume_tab, n_resume_tab;
    logic           r_mv_valid, n_mv_valid;
    logic [A_W-1:0] r_mv_dst, n_mv_dst;

    logic [A_W-1:0] cur_addr, rd_cell_addr, raddr, waddr;
    logic           we_char, we_color;
    logic [CHAR_W-1:0]  wchar;
    logic [COLOR_W-1:0] wcolor;
    logic           res_cell;

    logic [X_W-1:0] adv_x;
    logic [Y_W-1:0] adv_y, nl_y;
    logic [A_W-1:0] adv_base, nl_base, res_pos;
    logic           adv_scroll, nl_scroll;

    assign cur_addr     = r_base + A_W'(r_x);
    assign rd_cell_addr = A_W'(i_cmd.rd_row) * COL_A + A_W'(i_cmd.rd_col);
    assign o_init_busy  = (r_state == ST_INIT);

    // cursor step after a written glyph
    always_comb begin
        adv_x      = r_x + X_W'(1);
        adv_y      = r_y;
        adv_base   = r_base;
        adv_scroll = 1'b0;
        if (r_x == X_LAST) begin
            adv_x = '0;
            if (r_y == Y_LAST) begin
                adv_scroll = 1'b1;
            end else begin
                adv_y    = r_y + Y_W'(1);
                adv_base = r_base + COL_A;
            end
        end
    end

    // line feed step
    always_comb begin
        nl_y      = r_y;
        nl_base   = r_base;
        nl_scroll = 1'b0;
        if (r_y == Y_LAST) begin
            nl_scroll = 1'b1;
        end else begin
            nl_y    = r_y + Y_W'(1);
            nl_base = r_base + COL_A;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_x          = r_x;
        n_y          = r_y;
        n_base       = r_base;
        n_addr       = r_addr;
        n_tab_left   = r_tab_left;
        n_resume_tab = r_resume_tab;
        n_mv_valid   = 1'b0;
        n_mv_dst     = r_mv_dst;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        res_cell     = 1'b0;
        we_char      = 1'b0;
        we_color     = 1'b0;
        waddr        = cur_addr;
        wchar        = BLANK_CHAR;
        wcolor       = i_fill_color;
        raddr        = r_addr;

        unique case (r_state)
            ST_INIT: begin
                we_char  = 1'b1;
                we_color = 1'b1;
                waddr    = r_addr;
                wcolor   = RESET_COLOR;
                n_addr   = r_addr + A_W'(1);
                if (r_addr == CELL_LAST) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_GLYPH: begin
                            we_char = 1'b1;
                            wchar   = i_cmd.ch;
                            n_x     = adv_x;
                            n_y     = adv_y;
                            n_base  = adv_base;
                            if (adv_scroll) begin
                                n_addr       = COL_A;
                                n_resume_tab = 1'b0;
                                n_state      = ST_MOVE;
                            end else begin
                                o_res_push = 1'b1;
                            end
                        end
                        CMD_NEWLINE: begin
                            n_x    = '0;
                            n_y    = nl_y;
                            n_base = nl_base;
                            if (nl_scroll) begin
                                n_addr       = COL_A;
                                n_resume_tab = 1'b0;
                                n_state      = ST_MOVE;
                            end else begin
                                o_res_push = 1'b1;
                            end
                        end
                        CMD_RETURN: begin
                            n_x        = '0;
                            o_res_push = 1'b1;
                        end
                        CMD_TAB: begin
                            n_tab_left = i_tab_width;
                            n_state    = ST_TAB;
                        end
                        CMD_CLEAR: begin
                            n_addr  = '0;
                            n_state = ST_CLEAR;
                        end
                        CMD_READ: begin
                            raddr   = rd_cell_addr;
                            n_state = ST_READ;
                        end
                        default: begin
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_TAB: begin
                if (r_tab_left == '0) begin
                    o_res_push = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    we_char    = 1'b1;
                    n_x        = adv_x;
                    n_y        = adv_y;
                    n_base     = adv_base;
                    n_tab_left = r_tab_left - TAB_W'(1);
                    if (adv_scroll) begin
                        n_addr       = COL_A;
                        n_resume_tab = 1'b1;
                        n_state      = ST_MOVE;
                    end
                end
            end
            ST_MOVE: begin
                // read a cell one row down, write it one row up in the next cycle
                raddr      = r_addr;
                n_mv_valid = 1'b1;
                n_mv_dst   = r_addr - COL_A;
                if (r_mv_valid) begin
                    we_char  = 1'b1;
                    we_color = 1'b1;
                    waddr    = r_mv_dst;
                    wchar    = r_rd_char;
                    wcolor   = r_rd_color;
                end
                n_addr = r_addr + A_W'(1);
                if (r_addr == CELL_LAST) begin
                    n_addr  = BOTTOM_ROW;
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                we_char  = 1'b1;
                we_color = 1'b1;
                if (r_mv_valid) begin
                    // last move write still pending, fill waits for it
                    waddr  = r_mv_dst;
                    wchar  = r_rd_char;
                    wcolor = r_rd_color;
                end else begin
                    waddr  = r_addr;
                    n_addr = r_addr + A_W'(1);
                    if (r_addr == CELL_LAST) begin
                        n_addr = '0;
                        if (r_resume_tab) begin
                            n_state = ST_TAB;
                        end else begin
                            o_res_push = 1'b1;
                            n_state    = ST_IDLE;
                        end
                    end
                end
            end
            ST_CLEAR: begin
                we_char = 1'b1;
                waddr   = r_addr;
                n_addr  = r_addr + A_W'(1);
                if (r_addr == CELL_LAST) begin
                    n_addr     = '0;
                    n_x        = '0;
                    n_y        = '0;
                    n_base     = '0;
                    o_res_push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_READ: begin
                res_cell   = 1'b1;
                o_res_push = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result carries the cursor as it stands after the command
    assign res_pos = n_base + A_W'(n_x);

    always_comb begin
        o_res.cursor_col      = 7'(n_x);
        o_res.cursor_row      = 5'(n_y);
        o_res.cursor_position = 11'(res_pos);
        o_res.cell_char       = res_cell ? r_rd_char : '0;
        o_res.cell_color      = res_cell ? r_rd_color : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_x          <= '0;
            r_y          <= '0;
            r_base       <= '0;
            r_addr       <= '0;
            r_tab_left   <= '0;
            r_resume_tab <= 1'b0;
            r_mv_valid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_x          <= n_x;
            r_y          <= n_y;
            r_base       <= n_base;
            r_addr       <= n_addr;
            r_tab_left   <= n_tab_left;
            r_resume_tab <= n_resume_tab;
            r_mv_valid   <= n_mv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mv_dst <= n_mv_dst;
    end

    // character store
    always_ff @(posedge i_clk) begin
        if (we_char) begin
            r_char_mem[waddr] <= wchar;
        end
        r_rd_char <= r_char_mem[raddr];
    end

    // color store
    always_ff @(posedge i_clk) begin
        if (we_color) begin
            r_color_mem[waddr] <= wcolor;
        end
        r_rd_color <= r_color_mem[raddr];
    end

endmodule

@@ hdl/text_console_cursor_scroll_core.sv @@
// top level of the text console engine: ports, configuration registers,
// command and result queues; depends on tccs_pkg, tccs_front, tccs_fifo, tccs_back
//
// Text console engine for a COLUMNS x ROWS character screen with a
// character store and a color store, row-major. Each item is one of put
// character, clear screen or read one cell, and each gives exactly one
// result: the cursor column, row and linear position after the item, plus
// the read cell (zero for other items). Items enter through a queue
// (push/full) and results leave through a queue (pop/empty), so the two
// sides stall independently. Timing is set by the engine sequencer and its
// single write port per store: a printable character, return or no-op is
// done in the idle state, a read passes through a read state, a tab writes
// tab_width spaces, and a clear walks every cell. Any step that runs past
// the bottom row scrolls: the store is copied up one row through the read
// port and the bottom row is filled, then the item carries on. After reset
// a clearing pass over all COLUMNS*ROWS cells (2000 at the default size)
// fills the stores with spaces and color 0x07; full stays high meanwhile.
// Configuration (fill_color at index 0, tab_width at index 1) takes
// effect at once and is meant to be written while the block is idle.
module text_console_cursor_scroll_core #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    // item side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_char_code,
    input  logic [6:0]  i_read_col,
    input  logic [4:0]  i_read_row,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_position,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_color
);

    import tccs_pkg::*;

    localparam int CMD_W = $bits(t_cmd_item);
    localparam int RES_W = $bits(t_result);

    // configuration registers
    logic [COLOR_W-1:0] r_fill_color;
    logic [TAB_W-1:0]   r_tab_width;

    // front to command queue
    logic       front_push;
    t_cmd_item  front_cmd;
    logic       cmd_full, cmd_empty, cmd_pop;
    logic [CMD_W-1:0] cmd_rdata;
    t_cmd_item  cmd_head;

    // engine to result queue
    t_result    eng_res;
    logic       res_push, res_full;
    logic [RES_W-1:0] res_rdata;
    t_result    res_head;

    logic       init_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_color <= RESET_FILL;
            r_tab_width  <= RESET_TAB;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FILL_COLOR: r_fill_color <= i_cfg_wdata;
                CFG_TAB_WIDTH:  r_tab_width  <= i_cfg_wdata[TAB_W-1:0];
                default:        r_fill_color <= r_fill_color;
            endcase
        end
    end

    // no items taken while the stores are being initialized
    assign full = cmd_full || init_busy;

    tccs_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_push      (push && !full),
        .i_operation (i_operation),
        .i_char_code (i_char_code),
        .i_read_col  (i_read_col),
        .i_read_row  (i_read_row),
        .o_cmd_push  (front_push),
        .o_cmd       (front_cmd)
    );

    tccs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_wdata (front_cmd),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_rdata),
        .o_full  (cmd_full),
        .o_empty (cmd_empty)
    );

    assign cmd_head = cmd_rdata;

    tccs_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_head),
        .i_cmd_empty  (cmd_empty),
        .o_cmd_pop    (cmd_pop),
        .o_res        (eng_res),
        .o_res_push   (res_push),
        .i_res_full   (res_full),
        .i_fill_color (r_fill_color),
        .i_tab_width  (r_tab_width),
        .o_init_busy  (init_busy)
    );

    tccs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (eng_res),
        .i_pop   (pop),
        .o_rdata (res_rdata),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign res_head          = res_rdata;
    assign o_cursor_col      = res_head.cursor_col;
    assign o_cursor_row      = res_head.cursor_row;
    assign o_cursor_position = res_head.cursor_position;
    assign o_cell_char       = res_head.cell_char;
    assign o_cell_color      = res_head.cell_color;

endmodule

@@ test/text_console_cursor_scroll_core_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for text_console_cursor_scroll_core
// depends on tccs_pkg and the block's rtl; drives items, pops results, checks each field
module text_console_cursor_scroll_core_tb;
    import tccs_pkg::*;

    // screen geometry of the instance under test
    localparam int SCR_COLS = COLUMNS_DEF;
    localparam int SCR_ROWS = ROWS_DEF;
    localparam int CELLS    = SCR_COLS * SCR_ROWS;

    // operation code the block leaves unused
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int ITEMS_PER_SEG = 140;
    localparam int SEGMENTS      = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 200;
    // scrolls and clears cost about one store walk each; this is many times the slowest run
    localparam int LIMIT_CYCLES  = 10_000_000;

    // one row of the directed table; typed rows carry their own expected result
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
        logic [6:0] col;
        logic [4:0] row;
        logic       typed;
        t_result    res;
    } t_stim_row;

    // clock, reset and every input start at a known value
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_index = CFG_FILL_COLOR;
    logic [7:0]  i_cfg_wdata = '0;
    logic        push        = 1'b0;
    logic        pop         = 1'b0;
    logic [1:0]  i_operation = OP_PUT;
    logic [7:0]  i_char_code = '0;
    logic [6:0]  i_read_col  = '0;
    logic [4:0]  i_read_row  = '0;
    logic        full;
    logic        empty;
    logic [6:0]  o_cursor_col;
    logic [4:0]  o_cursor_row;
    logic [10:0] o_cursor_position;
    logic [7:0]  o_cell_char;
    logic [7:0]  o_cell_color;

    // shadow copy of the screen, the cursor and the two registers
    logic [7:0] scr_char [0:CELLS-1];
    logic [7:0] scr_attr [0:CELLS-1];
    int         scr_x;
    int         scr_y;
    logic [7:0] fill_attr;
    logic [3:0] tab_count;

    // cursor and cell results still owed by the block, oldest first
    t_result console_status_q [$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    // bumping hold_seq asks the receiver for one long hold-off
    int hold_seq       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    // directed items: extremes of every field, every operation, off-screen reads,
    // the unused code, clear with colors kept, tab at reset width
    t_stim_row directed_rows [21] = '{
        '{OP_READ,   8'h00, 7'd0,   5'd0,  1'b1, '{7'd0, 5'd0, 11'd0, BLANK_CHAR, RESET_COLOR}},
        '{OP_READ,   8'hFF, 7'd79,  5'd24, 1'b1, '{7'd0, 5'd0, 11'd0, BLANK_CHAR, RESET_COLOR}},
        '{OP_READ,   8'h00, 7'd80,  5'd0,  1'b1, '{7'd0, 5'd0, 11'd0, 8'h00, 8'h00}},
        '{OP_READ,   8'h00, 7'd0,   5'd25, 1'b1, '{7'd0, 5'd0, 11'd0, 8'h00, 8'h00}},
        '{OP_READ,   8'h00, 7'd127, 5'd31, 1'b1, '{7'd0, 5'd0, 11'd0, 8'h00, 8'h00}},
        '{OP_UNUSED, 8'hFF, 7'd127, 5'd31, 1'b1, '{7'd0, 5'd0, 11'd0, 8'h00, 8'h00}},
        '{OP_PUT,    8'h41, 7'd127, 5'd31, 1'b0, '0},
        '{OP_PUT,    8'h00, 7'd0,   5'd0,  1'b0, '0},
        '{OP_PUT,    8'hFF, 7'd0,   5'd0,  1'b0, '0},
        '{OP_PUT,    CHAR_TAB, 7'd0, 5'd0, 1'b0, '0},
        '{OP_READ,   8'h00, 7'd0,   5'd0,  1'b0, '0},
        '{OP_READ,   8'h00, 7'd2,   5'd0,  1'b0, '0},
        '{OP_PUT,    CHAR_CR, 7'd0, 5'd0,  1'b0, '0},
        '{OP_PUT,    CHAR_LF, 7'd0, 5'd0,  1'b0, '0},
        '{OP_PUT,    8'h7E, 7'd0,   5'd0,  1'b0, '0},
        '{OP_READ,   8'h00, 7'd0,   5'd1,  1'b0, '0},
        '{OP_UNUSED, 8'h00, 7'd0,   5'd0,  1'b0, '0},
        '{OP_CLEAR,  8'hFF, 7'd127, 5'd31, 1'b0, '0},
        '{OP_READ,   8'h00, 7'd0,   5'd0,  1'b0, '0},
        '{OP_PUT,    CHAR_TAB, 7'd0, 5'd0, 1'b0, '0},
        '{OP_READ,   8'h00, 7'd79,  5'd0,  1'b0, '0}
    };

    text_console_cursor_scroll_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .push              (push),
        .full              (full),
        .i_operation       (i_operation),
        .i_char_code       (i_char_code),
        .i_read_col        (i_read_col),
        .i_read_row        (i_read_row),
        .empty             (empty),
        .pop               (pop),
        .o_cursor_col      (o_cursor_col),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_position (o_cursor_position),
        .o_cell_char       (o_cell_char),
        .o_cell_color      (o_cell_color)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // wrap past the last column, then scroll one line when past the bottom row
    function automatic void wrap_and_scroll();
        if (scr_x >= SCR_COLS) begin
            scr_x = 0;
            scr_y++;
        end
        if (scr_y >= SCR_ROWS) begin
            for (int i = 0; i + SCR_COLS < CELLS; i++) begin
                scr_char[i] = scr_char[i + SCR_COLS];
                scr_attr[i] = scr_attr[i + SCR_COLS];
            end
            // fresh bottom row takes the fill color, not the reset color
            for (int i = CELLS - SCR_COLS; i < CELLS; i++) begin
                scr_char[i] = BLANK_CHAR;
                scr_attr[i] = fill_attr;
            end
            if (scr_y > 0)
                scr_y--;
        end
    endfunction

    // a glyph writes the character only; its color stays
    function automatic void put_glyph(logic [7:0] c);
        int idx;
        idx = scr_y * SCR_COLS + scr_x;
        if (idx < CELLS)
            scr_char[idx] = c;
        scr_x++;
        wrap_and_scroll();
    endfunction

    // applies one item to the shadow screen and returns the result it owes
    function automatic t_result console_apply(logic [1:0] op, logic [7:0] ch,
                                              logic [6:0] rc, logic [4:0] rr);
        t_result r;
        r = '0;
        case (op)
            OP_PUT: begin
                if (ch == CHAR_TAB) begin
                    // every space of the tab does its own wrap and scroll check
                    for (int i = 0; i < tab_count; i++)
                        put_glyph(BLANK_CHAR);
                    wrap_and_scroll();
                end else if (ch == CHAR_LF) begin
                    scr_y++;
                    scr_x = 0;
                    wrap_and_scroll();
                end else if (ch == CHAR_CR) begin
                    scr_x = 0;
                    wrap_and_scroll();
                end else begin
                    put_glyph(ch);
                end
            end
            OP_CLEAR: begin
                // characters blanked, colors kept
                for (int i = 0; i < CELLS; i++)
                    scr_char[i] = BLANK_CHAR;
                scr_x = 0;
                scr_y = 0;
            end
            OP_READ: begin
                // off-screen reads give zero cells
                if (rc < SCR_COLS && rr < SCR_ROWS) begin
                    r.cell_char  = scr_char[rr * SCR_COLS + rc];
                    r.cell_color = scr_attr[rr * SCR_COLS + rc];
                end
            end
            default: ;
        endcase
        r.cursor_col      = 7'(scr_x);
        r.cursor_row      = 5'(scr_y);
        r.cursor_position = 11'(scr_y * SCR_COLS + scr_x);
        return r;
    endfunction

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        mismatch_count++;
        $display("mismatch at result %0d: %s got %0d want %0d",
                 results_seen, what, got, want);
    endtask

    // both registers, on back-to-back edges, with no results owed by the block
    task automatic write_both(logic [7:0] fill, logic [3:0] tabs);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_FILL_COLOR;
        i_cfg_wdata <= fill;
        @(posedge i_clk);
        fill_attr = fill;
        i_cfg_index <= CFG_TAB_WIDTH;
        i_cfg_wdata <= {4'b0000, tabs};
        @(posedge i_clk);
        tab_count = tabs;
        i_cfg_wr_en <= 1'b0;
    endtask

    // offers one item, with random idle cycles first, and files its expected result
    task automatic offer_item(logic [1:0] op, logic [7:0] ch, logic [6:0] rc,
                              logic [4:0] rr, logic typed, t_result typed_res);
        t_result want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_operation <= op;
        i_char_code <= ch;
        i_read_col  <= rc;
        i_read_row  <= rr;
        @(posedge i_clk);
        while (full !== 1'b0)
            @(posedge i_clk);
        // accepted at this edge
        want = console_apply(op, ch, rc, rr);
        if (typed)
            want = typed_res;
        console_status_q.push_back(want);
    endtask

    // mostly printable text with line breaks and tabs, some reads near the
    // cursor and the bottom row, a little noise and the odd clear
    task automatic offer_random_item();
        int unsigned pick;
        int unsigned sel;
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [6:0]  rc;
        logic [4:0]  rr;
        pick = $urandom_range(0, 999);
        op   = OP_PUT;
        ch   = 8'($urandom_range(0, 255));
        rc   = 7'($urandom_range(0, 127));
        rr   = 5'($urandom_range(0, 31));
        if (pick < 550) begin
            if ($urandom_range(0, 3) != 0)
                ch = 8'($urandom_range(8'h20, 8'h7E));
        end else if (pick < 650) begin
            ch = CHAR_LF;
        end else if (pick < 690) begin
            ch = CHAR_CR;
        end else if (pick < 770) begin
            ch = CHAR_TAB;
        end else if (pick < 920) begin
            op  = OP_READ;
            sel = $urandom_range(0, 19);
            if (sel < 5)
                rr = 5'(scr_y);
            else if (sel < 10)
                rr = 5'(SCR_ROWS - 1);
            else if (sel < 17)
                rr = 5'($urandom_range(0, SCR_ROWS - 1));
            // the rest keep the full field range, off-screen included
            if (sel < 17)
                rc = 7'($urandom_range(0, SCR_COLS - 1));
        end else if (pick < 995) begin
            op = OP_UNUSED;
        end else begin
            op = OP_CLEAR;
        end
        offer_item(op, ch, rc, rr, 1'b0, '0);
    endtask

    // stop offering and wait for every owed result
    task automatic drain_results();
        push <= 1'b0;
        while (console_status_q.size() != 0)
            @(posedge i_clk);
    endtask

    // result side: check each popped result, then choose pop for the next cycle
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (console_status_q.size() == 0) begin
                flag_mismatch("result with nothing owed, position", o_cursor_position, 0);
            end else begin
                want = console_status_q.pop_front();
                if (o_cursor_col !== want.cursor_col)
                    flag_mismatch("cursor_col", o_cursor_col, want.cursor_col);
                if (o_cursor_row !== want.cursor_row)
                    flag_mismatch("cursor_row", o_cursor_row, want.cursor_row);
                if (o_cursor_position !== want.cursor_position)
                    flag_mismatch("cursor_position", o_cursor_position, want.cursor_position);
                if (o_cell_char !== want.cell_char)
                    flag_mismatch("cell_char", o_cell_char, want.cell_char);
                if (o_cell_color !== want.cell_color)
                    flag_mismatch("cell_color", o_cell_color, want.cell_color);
            end
            results_seen++;
        end
        // long hold-off lets both queues fill so full stalls the sender
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** text_console_cursor_scroll_core: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [7:0] seg_fill [SEGMENTS];
        logic [3:0] seg_tab  [SEGMENTS];

        // shadow state as after reset
        for (int i = 0; i < CELLS; i++) begin
            scr_char[i] = BLANK_CHAR;
            scr_attr[i] = RESET_COLOR;
        end
        scr_x     = 0;
        scr_y     = 0;
        fill_attr = RESET_FILL;
        tab_count = RESET_TAB;

        // register settings per segment: extremes of both, tab widths outside 1..8 too
        seg_fill = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'h5A,
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
        seg_tab  = '{4'd1, 4'd8, 4'd0, 4'd15,
                     4'($urandom_range(2, 7)), 4'($urandom_range(9, 14))};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values written back; the block may still be in its clearing pass
        write_both(RESET_FILL, RESET_TAB);

        send_idle_pct = 26;
        recv_idle_pct = 81;
        foreach (directed_rows[i])
            offer_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].col,
                       directed_rows[i].row, directed_rows[i].typed, directed_rows[i].res);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain_results();
            write_both(seg_fill[seg], seg_tab[seg]);
            // two segments per idling pattern: receiver sparse, then sender sparse, then neither
            if (seg < 2) begin
                send_idle_pct = 26;
                recv_idle_pct = 81;
            end else if (seg < 4) begin
                send_idle_pct = 81;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seg == 4)
                hold_seq <= hold_seq + 1;
            repeat (ITEMS_PER_SEG)
                offer_random_item();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (console_status_q.size() != 0)
            flag_mismatch("results never delivered", 0, console_status_q.size());

        if (mismatch_count == 0)
            $display("** text_console_cursor_scroll_core: PASSED **");
        else
            $display("** text_console_cursor_scroll_core: FAILED **");
        $finish;
    end

endmodule
